// File: design/bsd_pkg.sv
// bsd_pkg: shared types, codes and limits of the bmp stream decoder
// no dependencies; imported by the interfaces and every decoder module

package bsd_pkg;

  // largest accepted image width or height
  localparam int MAX_DIMENSION = 4096;
  // width of a stored dimension (holds MAX_DIMENSION itself)
  localparam int DIM_W = $clog2(MAX_DIMENSION + 1);
  // width of a column or row counter (holds MAX_DIMENSION - 1)
  localparam int CNT_W = $clog2(MAX_DIMENSION);
  // fixed widths of the result coordinates and of the file position
  localparam int COORD_W = 12;
  localparam int POS_W = 32;

  // parser phases
  localparam logic [2:0] PH_HEADER  = 3'd0;
  localparam logic [2:0] PH_PALETTE = 3'd1;
  localparam logic [2:0] PH_SKIP    = 3'd2;
  localparam logic [2:0] PH_PIXELS  = 3'd3;
  localparam logic [2:0] PH_HALT    = 3'd4;

  // result kinds
  localparam logic [1:0] KIND_PALETTE = 2'd0;
  localparam logic [1:0] KIND_INDEXED = 2'd1;
  localparam logic [1:0] KIND_RGB     = 2'd2;
  localparam logic [1:0] KIND_ERROR   = 2'd3;

  // error codes
  localparam logic [3:0] ERR_MAGIC       = 4'd0;
  localparam logic [3:0] ERR_INFO_SIZE   = 4'd1;
  localparam logic [3:0] ERR_ZERO_DIM    = 4'd2;
  localparam logic [3:0] ERR_PLANES      = 4'd3;
  localparam logic [3:0] ERR_DEPTH       = 4'd4;
  localparam logic [3:0] ERR_COMPRESSION = 4'd5;
  localparam logic [3:0] ERR_PALETTE     = 4'd6;
  localparam logic [3:0] ERR_OFFSET      = 4'd7;
  localparam logic [3:0] ERR_TOO_LARGE   = 4'd8;

  // header byte positions at which a little-endian field is complete
  localparam int HDR_POS_W = 6;
  localparam logic [HDR_POS_W-1:0] POS_MAGIC    = 6'd1;
  localparam logic [HDR_POS_W-1:0] POS_OFFSET   = 6'd13;
  localparam logic [HDR_POS_W-1:0] POS_INFO     = 6'd17;
  localparam logic [HDR_POS_W-1:0] POS_WIDTH    = 6'd21;
  localparam logic [HDR_POS_W-1:0] POS_HEIGHT   = 6'd25;
  localparam logic [HDR_POS_W-1:0] POS_PLANES   = 6'd27;
  localparam logic [HDR_POS_W-1:0] POS_DEPTH    = 6'd29;
  localparam logic [HDR_POS_W-1:0] POS_COMPRESS = 6'd33;
  localparam logic [HDR_POS_W-1:0] POS_PALETTE  = 6'd49;
  localparam logic [HDR_POS_W-1:0] POS_HDR_END  = 6'd53;

  // header constants
  localparam logic [7:0]  MAGIC_B       = 8'h42;
  localparam logic [7:0]  MAGIC_M       = 8'h4d;
  localparam logic [31:0] INFO_SIZE     = 32'd40;
  localparam logic [15:0] DEPTH_8       = 16'd8;
  localparam logic [15:0] DEPTH_24      = 16'd24;
  localparam logic [31:0] PALETTE_MAX   = 32'd256;
  localparam int          PAL_W         = 9;
  localparam logic [PAL_W-1:0] PALETTE_FULL = 9'd256;
  localparam int          START_W       = 11;
  localparam logic [START_W-1:0] HEADER_BYTES = 11'd54;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_file;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         item_kind;
    logic [COORD_W-1:0] column;
    logic [COORD_W-1:0] dest_row;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic [7:0]         colour_index;
    logic [3:0]         error_code;
    logic               last_item;
  } out_item_t;

  // parser result toward the output register
  typedef struct packed {
    logic      valid;
    out_item_t item;
  } parse_res_t;

  // parser status
  typedef struct packed {
    logic halted;
  } parse_stat_t;

endpackage

// File: design/bsd_in_if.sv
// bsd_in_if: valid/ready channel carrying one file byte per beat
// depends on bsd_pkg

interface bsd_in_if import bsd_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: design/bsd_out_if.sv
// bsd_out_if: valid/ready channel carrying one decoded item per beat
// depends on bsd_pkg

interface bsd_out_if import bsd_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: design/bmp_stream_decoder.sv
// bmp_stream_decoder: byte-serial decoder for 8/24-bit uncompressed bmp files
// a byte is registered in the input register, then its result in the output register
// throughput: one byte per cycle while the result register has room, set by the single parser pass per byte
// an output beat waiting for ready stalls the input after one buffered byte
// reset (rst, synchronous) empties both registers and restarts the header parse
// depends on bsd_pkg, bsd_in_if, bsd_out_if, bsd_in_stage, bsd_parser, bsd_out_stage

module bmp_stream_decoder import bsd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  bsd_in_if.sink    stream,
  bsd_out_if.source result
);

  logic        stage_valid;
  in_item_t    stage_item;
  logic        out_free;
  logic        advance;
  parse_res_t  parse_res;
  parse_stat_t parse_stat;

  // one byte moves through the parser when the result register has room
  assign advance = stage_valid && out_free;

  bsd_in_stage u_in_stage (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (stream.valid),
    .in_item     (stream.data),
    .in_ready    (stream.ready),
    .pop         (advance),
    .stage_valid (stage_valid),
    .stage_item  (stage_item)
  );

  bsd_parser u_parser (
    .clk  (clk),
    .rst  (rst),
    .go   (advance),
    .item (stage_item),
    .res  (parse_res),
    .stat (parse_stat)
  );

  bsd_out_stage u_out_stage (
    .clk       (clk),
    .rst       (rst),
    .load      (advance),
    .res       (parse_res),
    .free      (out_free),
    .out_valid (result.valid),
    .out_item  (result.data),
    .out_ready (result.ready)
  );

  // a full input register with a blocked result register takes no beat
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    stage_valid && !out_free |-> !stream.ready)
    else $error("input taken while pipeline blocked");

  // an error beat always closes the stream
  a_error_is_last: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.data.item_kind == KIND_ERROR |-> result.data.last_item)
    else $error("error beat without last_item");

  // the parser halts after the final pixel or an error
  a_halt_after_last: assert property (@(posedge clk) disable iff (rst)
    advance && parse_res.valid && parse_res.item.last_item |=> parse_stat.halted)
    else $error("parser not halted after last beat");

  // palette beats carry no coordinates
  a_palette_coords: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.data.item_kind == KIND_PALETTE |->
      result.data.column == '0 && result.data.dest_row == '0)
    else $error("palette beat with coordinates");

endmodule

// File: design/bsd_in_stage.sv
// bsd_in_stage: input register holding one accepted byte beat
// depends on bsd_pkg

module bsd_in_stage import bsd_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  in_item_t in_item,
  output logic     in_ready,
  input  logic     pop,
  output logic     stage_valid,
  output in_item_t stage_item
);

  // free when empty or being consumed this cycle
  assign in_ready = !stage_valid || pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_item <= in_item;
    end
  end

endmodule

// File: design/bsd_parser.sv
// bsd_parser: header, palette and pixel parsing state with per-byte logic
// depends on bsd_pkg

module bsd_parser import bsd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        go,
  input  in_item_t    item,
  output parse_res_t  res,
  output parse_stat_t stat
);

  logic [2:0]        phase, phase_next;
  logic [POS_W-1:0]  file_position, file_position_next;
  logic [31:0]       header_word, header_word_next;
  logic [31:0]       pixel_data_offset, pixel_data_offset_next;
  logic [DIM_W-1:0]  image_width, image_width_next;
  logic [DIM_W-1:0]  image_height, image_height_next;
  logic              width_high, width_high_next;
  logic              height_high, height_high_next;
  logic              planes_one, planes_one_next;
  logic              depth8, depth8_next;
  logic              depth24, depth24_next;
  logic              compress_nz, compress_nz_next;
  logic              pal_big, pal_big_next;
  logic              pal_zero, pal_zero_next;
  logic [PAL_W-1:0]  pal_count, pal_count_next;
  logic              depth_is_24, depth_is_24_next;
  logic [PAL_W-1:0]  palette_remaining, palette_remaining_next;
  logic [7:0]        palette_slot, palette_slot_next;
  logic [CNT_W-1:0]  column_count, column_count_next;
  logic [CNT_W-1:0]  row_count, row_count_next;
  logic [1:0]        byte_in_group, byte_in_group_next;
  logic [15:0]       held_bytes, held_bytes_next;
  logic [1:0]        pad_remaining, pad_remaining_next;

  assign stat.halted = (phase == PH_HALT);

  always_comb begin
    logic [2:0]         ph;
    logic [POS_W-1:0]   cur;
    logic [POS_W-1:0]   pos_inc;
    logic [7:0]         b;
    logic [31:0]        hw;
    logic               w_zero, h_zero, w_big, h_big;
    logic [PAL_W-1:0]   entries;
    logic [START_W-1:0] data_start;
    logic [DIM_W-1:0]   col_inc, row_inc;
    logic [1:0]         w2;
    logic               emit_px;
    logic [1:0]         px_kind;
    logic [7:0]         px_r, px_g, px_b, px_idx;
    logic               enter;

    phase_next             = phase;
    file_position_next     = file_position;
    header_word_next       = header_word;
    pixel_data_offset_next = pixel_data_offset;
    image_width_next       = image_width;
    image_height_next      = image_height;
    width_high_next        = width_high;
    height_high_next       = height_high;
    planes_one_next        = planes_one;
    depth8_next            = depth8;
    depth24_next           = depth24;
    compress_nz_next       = compress_nz;
    pal_big_next           = pal_big;
    pal_zero_next          = pal_zero;
    pal_count_next         = pal_count;
    depth_is_24_next       = depth_is_24;
    palette_remaining_next = palette_remaining;
    palette_slot_next      = palette_slot;
    column_count_next      = column_count;
    row_count_next         = row_count;
    byte_in_group_next     = byte_in_group;
    held_bytes_next        = held_bytes;
    pad_remaining_next     = pad_remaining;
    res                    = '0;
    emit_px                = 1'b0;
    px_kind                = KIND_INDEXED;
    px_r                   = '0;
    px_g                   = '0;
    px_b                   = '0;
    px_idx                 = '0;
    enter                  = 1'b0;

    // start of file restarts at byte zero of the header
    b       = item.data_byte;
    ph      = item.start_of_file ? PH_HEADER : phase;
    cur     = item.start_of_file ? '0 : file_position;
    pos_inc = cur + POS_W'(1);
    hw      = {b, header_word[31:8]};

    // header sanity terms
    w_zero     = !width_high && (image_width == '0);
    h_zero     = !height_high && (image_height == '0);
    w_big      = width_high || (image_width > DIM_W'(MAX_DIMENSION));
    h_big      = height_high || (image_height > DIM_W'(MAX_DIMENSION));
    entries    = pal_zero ? PALETTE_FULL : pal_count;
    data_start = depth24 ? HEADER_BYTES : HEADER_BYTES + {entries, 2'b00};

    // row bookkeeping terms
    col_inc = DIM_W'(column_count) + DIM_W'(1);
    row_inc = DIM_W'(row_count) + DIM_W'(1);
    w2      = image_width[1:0];

    if (ph != PH_HALT) begin
      phase_next         = ph;
      file_position_next = pos_inc;
      case (ph)
        // header bytes: collect little-endian fields
        PH_HEADER: begin
          header_word_next = hw;
          case (cur[HDR_POS_W-1:0])
            POS_MAGIC: begin
              if (hw[23:16] != MAGIC_B || hw[31:24] != MAGIC_M) begin
                res.valid           = 1'b1;
                res.item.item_kind  = KIND_ERROR;
                res.item.error_code = ERR_MAGIC;
                phase_next          = PH_HALT;
              end
            end
            POS_OFFSET: pixel_data_offset_next = hw;
            POS_INFO: begin
              if (hw != INFO_SIZE) begin
                res.valid           = 1'b1;
                res.item.item_kind  = KIND_ERROR;
                res.item.error_code = ERR_INFO_SIZE;
                phase_next          = PH_HALT;
              end
            end
            POS_WIDTH: begin
              image_width_next = hw[DIM_W-1:0];
              width_high_next  = |hw[31:DIM_W];
            end
            POS_HEIGHT: begin
              image_height_next = hw[DIM_W-1:0];
              height_high_next  = |hw[31:DIM_W];
            end
            POS_PLANES: planes_one_next = (hw[31:16] == 16'd1);
            POS_DEPTH: begin
              depth8_next  = (hw[31:16] == DEPTH_8);
              depth24_next = (hw[31:16] == DEPTH_24);
            end
            POS_COMPRESS: compress_nz_next = (hw != '0);
            POS_PALETTE: begin
              pal_big_next   = (hw > PALETTE_MAX);
              pal_zero_next  = (hw == '0);
              pal_count_next = hw[PAL_W-1:0];
            end
            POS_HDR_END: begin
              res.item.item_kind = KIND_ERROR;
              res.valid          = 1'b1;
              phase_next         = PH_HALT;
              if (w_zero || h_zero) begin
                res.item.error_code = ERR_ZERO_DIM;
              end else if (!planes_one) begin
                res.item.error_code = ERR_PLANES;
              end else if (!depth8 && !depth24) begin
                res.item.error_code = ERR_DEPTH;
              end else if (compress_nz) begin
                res.item.error_code = ERR_COMPRESSION;
              end else if (!depth24 && pal_big) begin
                res.item.error_code = ERR_PALETTE;
              end else if (w_big || h_big) begin
                res.item.error_code = ERR_TOO_LARGE;
              end else if (pixel_data_offset < 32'(data_start)) begin
                res.item.error_code = ERR_OFFSET;
              end else begin
                res = '0;
                if (depth24) begin
                  enter = 1'b1;
                end else begin
                  phase_next             = PH_PALETTE;
                  palette_remaining_next = entries;
                  palette_slot_next      = '0;
                  byte_in_group_next     = '0;
                  header_word_next       = '0;
                end
              end
              depth_is_24_next = depth24;
            end
            default: ;
          endcase
        end
        // palette: four bytes per entry, stored B,G,R,reserved
        PH_PALETTE: begin
          header_word_next   = hw;
          byte_in_group_next = byte_in_group + 2'd1;
          if (byte_in_group == 2'd3) begin
            res.valid                 = 1'b1;
            res.item.item_kind        = KIND_PALETTE;
            res.item.red              = hw[23:16];
            res.item.green            = hw[15:8];
            res.item.blue             = hw[7:0];
            res.item.colour_index     = palette_slot;
            palette_slot_next         = palette_slot + 8'd1;
            palette_remaining_next    = palette_remaining - PAL_W'(1);
            if (palette_remaining == PAL_W'(1)) begin
              enter = 1'b1;
            end
          end
        end
        // gap up to the pixel offset
        PH_SKIP: begin
          if (pos_inc == pixel_data_offset) begin
            enter = 1'b1;
          end
        end
        // pixel data with row padding
        PH_PIXELS: begin
          if (pad_remaining != 2'd0) begin
            pad_remaining_next = pad_remaining - 2'd1;
          end else if (!depth_is_24) begin
            emit_px = 1'b1;
            px_kind = KIND_INDEXED;
            px_idx  = b;
          end else if (byte_in_group == 2'd0) begin
            held_bytes_next    = {8'd0, b};
            byte_in_group_next = 2'd1;
          end else if (byte_in_group == 2'd1) begin
            held_bytes_next    = {b, held_bytes[7:0]};
            byte_in_group_next = 2'd2;
          end else begin
            byte_in_group_next = 2'd0;
            emit_px            = 1'b1;
            px_kind            = KIND_RGB;
            px_r               = b;
            px_g               = held_bytes[15:8];
            px_b               = held_bytes[7:0];
          end
        end
        default: phase_next = PH_HALT;
      endcase
    end

    // pixel result and column/row advance
    if (emit_px) begin
      res.valid             = 1'b1;
      res.item.item_kind    = px_kind;
      res.item.column       = COORD_W'(column_count);
      res.item.dest_row     = COORD_W'(image_height - DIM_W'(1) - DIM_W'(row_count));
      res.item.red          = px_r;
      res.item.green        = px_g;
      res.item.blue         = px_b;
      res.item.colour_index = px_idx;
      column_count_next     = column_count + CNT_W'(1);
      if (col_inc >= image_width) begin
        column_count_next = '0;
        if (row_inc >= image_height) begin
          res.item.last_item = 1'b1;
          phase_next         = PH_HALT;
        end else begin
          row_count_next     = row_count + CNT_W'(1);
          pad_remaining_next = depth_is_24 ? 2'(2'd0 - 2'(w2 + {w2[0], 1'b0}))
                                           : 2'(2'd0 - w2);
        end
      end
    end

    // errors always close the stream
    if (res.valid && res.item.item_kind == KIND_ERROR) begin
      res.item.last_item = 1'b1;
    end

    // entry into the pixel data area
    if (enter) begin
      column_count_next  = '0;
      row_count_next     = '0;
      byte_in_group_next = '0;
      held_bytes_next    = '0;
      pad_remaining_next = '0;
      phase_next         = (pos_inc == pixel_data_offset) ? PH_PIXELS : PH_SKIP;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HEADER;
      file_position <= '0;
    end else if (go) begin
      phase         <= phase_next;
      file_position <= file_position_next;
    end
  end

  // field and counter registers
  always_ff @(posedge clk) begin
    if (go) begin
      header_word       <= header_word_next;
      pixel_data_offset <= pixel_data_offset_next;
      image_width       <= image_width_next;
      image_height      <= image_height_next;
      width_high        <= width_high_next;
      height_high       <= height_high_next;
      planes_one        <= planes_one_next;
      depth8            <= depth8_next;
      depth24           <= depth24_next;
      compress_nz       <= compress_nz_next;
      pal_big           <= pal_big_next;
      pal_zero          <= pal_zero_next;
      pal_count         <= pal_count_next;
      depth_is_24       <= depth_is_24_next;
      palette_remaining <= palette_remaining_next;
      palette_slot      <= palette_slot_next;
      column_count      <= column_count_next;
      row_count         <= row_count_next;
      byte_in_group     <= byte_in_group_next;
      held_bytes        <= held_bytes_next;
      pad_remaining     <= pad_remaining_next;
    end
  end

endmodule

// File: design/bsd_out_stage.sv
// bsd_out_stage: result register toward the output channel
// depends on bsd_pkg

module bsd_out_stage import bsd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       load,
  input  parse_res_t res,
  output logic       free,
  output logic       out_valid,
  output out_item_t  out_item,
  input  logic       out_ready
);

  // space when empty or the held beat leaves this cycle
  assign free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= res.valid;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load && res.valid) begin
      out_item <= res.item;
    end
  end

endmodule

// File: sim/bmp_stream_decoder_test.sv
// bmp_stream_decoder_test: self-checking bench for the byte-serial bmp decoder
// builds bmp files in place, streams them with random idling and checks each result beat
// depends on bsd_pkg, bsd_in_if, bsd_out_if and the bmp_stream_decoder rtl

module bmp_stream_decoder_test import bsd_pkg::*; ();

  localparam int CYCLE_LIMIT = 500000;
  localparam int HOLD_CYCLES = 300;
  localparam logic [3:0] NO_ERROR = 4'd0;

  // first byte of each little-endian header field
  localparam int OFS_AT      = 10;
  localparam int INFO_AT     = 14;
  localparam int WIDTH_AT    = 18;
  localparam int HEIGHT_AT   = 22;
  localparam int PLANES_AT   = 26;
  localparam int DEPTH_AT    = 28;
  localparam int COMPRESS_AT = 30;
  localparam int PALETTE_AT  = 46;
  localparam int HEADER_LEN  = 54;

  // decoder model plus the queue of decoded items still to arrive
  class bmp_item_board;
    out_item_t expected_items[$];
    int errors = 0;
    int palette_beats = 0;
    int pixel_beats = 0;
    int error_beats = 0;

    logic [2:0]  phase;
    logic [31:0] pos, word, offset, width, height;
    logic [31:0] planes, depth, compression, pal_count, pal_left, pal_slot, col, row;
    logic        is24;
    logic [1:0]  grp, pad;
    logic [15:0] held;

    function new();
      clear();
    endfunction

    function void clear();
      phase = PH_HEADER;
      pos = 0; word = 0; offset = 0; width = 0; height = 0;
      planes = 0; depth = 0; compression = 0; pal_count = 0; pal_left = 0;
      pal_slot = 0; col = 0; row = 0; is24 = 0; grp = 0; pad = 0; held = 0;
    endfunction

    function void queue_item(logic [1:0] kind, logic [31:0] c, logic [31:0] dr,
                             logic [7:0] r, logic [7:0] g, logic [7:0] b,
                             logic [7:0] idx, logic [3:0] code, logic last);
      out_item_t it;
      it.item_kind = kind;
      it.column = c[COORD_W-1:0];
      it.dest_row = dr[COORD_W-1:0];
      it.red = r;
      it.green = g;
      it.blue = b;
      it.colour_index = idx;
      it.error_code = code;
      it.last_item = last;
      expected_items = {expected_items, it};
    endfunction

    function void halt_with(logic [3:0] code);
      phase = PH_HALT;
      queue_item(KIND_ERROR, 0, 0, 0, 0, 0, 0, code, 1'b1);
    endfunction

    function void enter_pixels();
      col = 0; row = 0; grp = 0; held = 0; pad = 0;
      phase = (pos == offset) ? PH_PIXELS : PH_SKIP;
    endfunction

    // header checks in priority order, then on to palette or pixel data
    function void end_header();
      logic [31:0] entries, data_start;
      if (width == 0 || height == 0) begin halt_with(ERR_ZERO_DIM); return; end
      if (planes != 1) begin halt_with(ERR_PLANES); return; end
      if (depth != 32'(DEPTH_8) && depth != 32'(DEPTH_24)) begin
        halt_with(ERR_DEPTH);
        return;
      end
      if (compression != 0) begin halt_with(ERR_COMPRESSION); return; end
      is24 = (depth == 32'(DEPTH_24));
      entries = 0;
      if (!is24) begin
        if (pal_count > PALETTE_MAX) begin halt_with(ERR_PALETTE); return; end
        entries = (pal_count == 0) ? PALETTE_MAX : pal_count;
      end
      data_start = HEADER_LEN + 4 * entries;
      if (width > MAX_DIMENSION || height > MAX_DIMENSION) begin
        halt_with(ERR_TOO_LARGE);
        return;
      end
      if (offset < data_start) begin halt_with(ERR_OFFSET); return; end
      if (is24) begin
        enter_pixels();
      end else begin
        pal_left = entries;
        pal_slot = 0;
        grp = 0;
        word = 0;
        phase = PH_PALETTE;
      end
    endfunction

    // one pixel out, advancing column and bottom-up row
    function void emit_pixel(logic [1:0] kind, logic [7:0] r, logic [7:0] g,
                             logic [7:0] b, logic [7:0] idx);
      logic [31:0] c, dr, neg;
      logic last;
      c = col;
      dr = height - 1 - row;
      last = 1'b0;
      col = col + 1;
      if (col >= width) begin
        col = 0;
        if (row + 1 >= height) begin
          last = 1'b1;
          phase = PH_HALT;
        end else begin
          row = row + 1;
          neg = is24 ? (32'd0 - 32'd3 * width) : (32'd0 - width);
          pad = neg[1:0];
        end
      end
      queue_item(kind, c, dr, r, g, b, idx, NO_ERROR, last);
    endfunction

    // advance the model by one accepted input beat
    function void take_byte(in_item_t it);
      logic [7:0]  b;
      logic [31:0] cur;
      b = it.data_byte;
      if (it.start_of_file) clear();
      if (phase == PH_HALT) return;
      cur = pos;
      pos = cur + 1;
      case (phase)
        PH_HEADER: begin
          word = {b, word[31:8]};
          case (cur)
            32'(POS_MAGIC):
              if (word[23:16] != MAGIC_B || word[31:24] != MAGIC_M) halt_with(ERR_MAGIC);
            32'(POS_OFFSET): offset = word;
            32'(POS_INFO): if (word != INFO_SIZE) halt_with(ERR_INFO_SIZE);
            32'(POS_WIDTH): width = word;
            32'(POS_HEIGHT): height = word;
            32'(POS_PLANES): planes = 32'(word[31:16]);
            32'(POS_DEPTH): depth = 32'(word[31:16]);
            32'(POS_COMPRESS): compression = word;
            32'(POS_PALETTE): pal_count = word;
            32'(POS_HDR_END): end_header();
            default: ;
          endcase
        end
        PH_PALETTE: begin
          word = {b, word[31:8]};
          if (grp != 2'd3) begin
            grp = grp + 2'd1;
          end else begin
            grp = 0;
            queue_item(KIND_PALETTE, 0, 0, word[23:16], word[15:8], word[7:0],
                       pal_slot[7:0], NO_ERROR, 1'b0);
            pal_slot = pal_slot + 1;
            pal_left = pal_left - 1;
            if (pal_left == 0) enter_pixels();
          end
        end
        PH_SKIP: begin
          if (pos == offset) enter_pixels();
        end
        PH_PIXELS: begin
          if (pad != 0) begin
            pad = pad - 2'd1;
          end else if (!is24) begin
            emit_pixel(KIND_INDEXED, 0, 0, 0, b);
          end else if (grp == 0) begin
            held = {8'd0, b};
            grp = 1;
          end else if (grp == 1) begin
            held[15:8] = b;
            grp = 2;
          end else begin
            grp = 0;
            emit_pixel(KIND_RGB, b, held[15:8], held[7:0], 0);
          end
        end
        default: phase = PH_HALT;
      endcase
    endfunction

    function void same_field(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected %0d, got %0d", field, want, got);
        errors++;
      end
    endfunction

    // compare one output beat against the oldest decoded item
    function void match_item(out_item_t got);
      out_item_t want;
      if (expected_items.size() == 0) begin
        $error("result beat with nothing pending: item_kind %0d", got.item_kind);
        errors++;
        return;
      end
      want = expected_items.pop_front();
      same_field("item_kind", 32'(want.item_kind), 32'(got.item_kind));
      same_field("column", 32'(want.column), 32'(got.column));
      same_field("dest_row", 32'(want.dest_row), 32'(got.dest_row));
      same_field("red", 32'(want.red), 32'(got.red));
      same_field("green", 32'(want.green), 32'(got.green));
      same_field("blue", 32'(want.blue), 32'(got.blue));
      same_field("colour_index", 32'(want.colour_index), 32'(got.colour_index));
      same_field("error_code", 32'(want.error_code), 32'(got.error_code));
      same_field("last_item", 32'(want.last_item), 32'(got.last_item));
      case (want.item_kind)
        KIND_PALETTE: palette_beats++;
        KIND_ERROR: error_beats++;
        default: pixel_beats++;
      endcase
    endfunction

    function void leftover();
      if (expected_items.size() != 0) begin
        $error("%0d decoded items never arrived", expected_items.size());
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  bsd_in_if  byte_ch ();
  bsd_out_if item_ch ();

  bmp_stream_decoder dut (
    .clk    (clk),
    .rst    (rst),
    .stream (byte_ch),
    .result (item_ch)
  );

  bmp_item_board board = new();
  logic [7:0] file_bytes[$];
  int send_idle = 0;
  int recv_stall = 0;
  int hold_left = 0;
  int cycles = 0;
  int bytes_sent = 0;
  int files_sent = 0;
  int send_plan[4] = '{0, 54, 0, 15};
  int stall_plan[4] = '{0, 0, 54, 15};

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // beats taken on either channel feed the board
  always @(posedge clk) begin
    if (!rst) begin
      if (byte_ch.valid && byte_ch.ready) board.take_byte(byte_ch.data);
      if (item_ch.valid && item_ch.ready) board.match_item(item_ch.data);
    end
  end

  // receiver: random stalls, or a counted hold-off when one is requested
  initial begin
    item_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        item_ch.ready <= 1'b0;
      end else begin
        item_ch.ready <= ($urandom_range(99) >= recv_stall);
      end
    end
  end

  // run limit
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("bmp_stream_decoder_test: errors");
    $finish;
  end

  function automatic void put_le(int at, logic [31:0] v, int n);
    for (int i = 0; i < n; i++) file_bytes[at + i] = v[8*i +: 8];
  endfunction

  // well-formed file with random filler, palette, gap and pixel rows
  function automatic void make_bmp(logic [15:0] bits, logic [31:0] w, logic [31:0] h,
                                   logic [31:0] pal, int gap, int rows, int tail);
    int pal_bytes, stride, px;
    file_bytes.delete();
    if (bits == DEPTH_8) pal_bytes = (pal == 0) ? 1024 : ((pal <= PALETTE_MAX) ? 4 * pal : 0);
    else pal_bytes = (pal <= 4) ? 4 * pal : 0;
    repeat (HEADER_LEN + pal_bytes) file_bytes = {file_bytes, 8'($urandom)};
    file_bytes[0] = MAGIC_B;
    file_bytes[1] = MAGIC_M;
    put_le(OFS_AT, HEADER_LEN + pal_bytes + gap, 4);
    put_le(INFO_AT, INFO_SIZE, 4);
    put_le(WIDTH_AT, w, 4);
    put_le(HEIGHT_AT, h, 4);
    put_le(PLANES_AT, 1, 2);
    put_le(DEPTH_AT, 32'(bits), 2);
    put_le(COMPRESS_AT, 0, 4);
    put_le(PALETTE_AT, pal, 4);
    if (gap > 0) repeat (gap) file_bytes = {file_bytes, 8'($urandom)};
    stride = 0;
    if (w <= MAX_DIMENSION) begin
      px = (bits == DEPTH_24) ? 3 * w : w;
      stride = (px + 3) & ~3;
    end
    repeat (rows * stride + tail) file_bytes = {file_bytes, 8'($urandom)};
  endfunction

  // break the header so that the given check fires
  function automatic void corrupt_header(logic [3:0] code);
    int at;
    at = $urandom_range(1);
    case (code)
      ERR_MAGIC: file_bytes[at] = file_bytes[at] ^ 8'($urandom_range(1, 255));
      ERR_INFO_SIZE: put_le(INFO_AT, INFO_SIZE + $urandom_range(1, 1000), 4);
      ERR_ZERO_DIM: put_le(at ? WIDTH_AT : HEIGHT_AT, 0, 4);
      ERR_PLANES: put_le(PLANES_AT, $urandom_range(1) ? 0 : $urandom_range(2, 65535), 2);
      ERR_DEPTH: put_le(DEPTH_AT, $urandom_range(25, 65535), 2);
      ERR_COMPRESSION: put_le(COMPRESS_AT, $urandom_range(1, 6), 4);
      ERR_PALETTE: begin
        put_le(DEPTH_AT, 32'(DEPTH_8), 2);
        put_le(PALETTE_AT, $urandom_range(257, 100000), 4);
      end
      ERR_OFFSET: put_le(OFS_AT, $urandom_range(0, HEADER_LEN - 1), 4);
      default: put_le(at ? WIDTH_AT : HEIGHT_AT, MAX_DIMENSION + $urandom_range(1, 100000), 4);
    endcase
  endfunction

  // one input beat, with random idle cycles ahead of it
  task automatic send_byte(logic [7:0] b, logic sof);
    while ($urandom_range(99) < send_idle) begin
      byte_ch.valid <= 1'b0;
      @(negedge clk);
    end
    byte_ch.valid <= 1'b1;
    byte_ch.data.data_byte <= b;
    byte_ch.data.start_of_file <= sof;
    @(posedge clk);
    while (!byte_ch.ready) @(posedge clk);
    @(negedge clk);
    bytes_sent++;
  endtask

  task automatic send_file(logic mark);
    foreach (file_bytes[i]) send_byte(file_bytes[i], mark && i == 0);
    files_sent++;
  endtask

  task automatic drain();
    byte_ch.valid <= 1'b0;
    while (board.expected_items.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  // mostly small well-formed files, plus truncated, broken and noise traffic
  task automatic random_file();
    int pick, cut, n, gap;
    logic [15:0] bits;
    logic [31:0] w, h, pal;
    pick = $urandom_range(99);
    bits = $urandom_range(1) ? DEPTH_24 : DEPTH_8;
    w = $urandom_range(1, 6);
    h = $urandom_range(1, 4);
    if (bits == DEPTH_8) pal = $urandom_range(1, 4);
    else pal = ($urandom_range(3) == 0) ? 300 : $urandom_range(0, 2);
    gap = $urandom_range(1) ? 0 : $urandom_range(1, 3);
    if (pick >= 90) begin
      n = $urandom_range(1, 8);
      repeat (n) send_byte(8'($urandom), $urandom_range(3) == 0);
    end else begin
      make_bmp(bits, w, h, pal, gap, (pick < 70) ? h : 0, $urandom_range(0, 2));
      if (pick >= 70) begin
        corrupt_header(4'($urandom_range(ERR_MAGIC, ERR_TOO_LARGE)));
      end else if (pick >= 55) begin
        cut = $urandom_range(1, file_bytes.size() - 1);
        while (file_bytes.size() > cut) void'(file_bytes.pop_back());
      end
      send_file(1'b1);
    end
  endtask

  initial begin
    int goal;
    byte_ch.valid = 1'b0;
    byte_ch.data = '0;
    repeat (3) @(negedge clk);
    rst <= 1'b0;

    // directed files, no idling
    // first file after reset without a start mark, trailing bytes ignored
    make_bmp(DEPTH_24, 2, 2, 0, 0, 2, 3);
    send_file(1'b0);
    // 8-bit, pixel data right after the palette, one pad byte per row
    make_bmp(DEPTH_8, 3, 2, 2, 0, 2, 0);
    send_file(1'b1);
    // palette count zero means a full palette, so one byte short fails the offset
    make_bmp(DEPTH_8, 1, 1, 0, -1, 0, 0);
    while (file_bytes.size() > HEADER_LEN) void'(file_bytes.pop_back());
    send_file(1'b1);
    // full palette followed by a gap, cut short by the next start
    make_bmp(DEPTH_8, 1, 1, 0, 2, 1, 0);
    while (file_bytes.size() > HEADER_LEN + 40) void'(file_bytes.pop_back());
    send_file(1'b1);
    // 24-bit ignores a palette count above the limit, skips to the offset
    make_bmp(DEPTH_24, 3, 2, 300, 5, 2, 0);
    send_file(1'b1);
    // offset one byte short of the palette end
    make_bmp(DEPTH_8, 2, 2, 4, -1, 2, 0);
    send_file(1'b1);
    // every header check
    for (int code = int'(ERR_MAGIC); code <= int'(ERR_TOO_LARGE); code++) begin
      make_bmp(DEPTH_24, 2, 2, 0, 0, 0, 0);
      corrupt_header(4'(code));
      send_file(1'b1);
    end
    // one row while the receiver holds off and the input backs up
    hold_left = HOLD_CYCLES;
    make_bmp(DEPTH_8, 32, 1, 1, 0, 1, 0);
    send_file(1'b1);
    // tallest image, cut short by the next start
    make_bmp(DEPTH_8, 1, MAX_DIMENSION, 1, 0, 3, 0);
    send_file(1'b1);
    make_bmp(DEPTH_24, MAX_DIMENSION, MAX_DIMENSION, 0, 0, 0, 30);
    send_file(1'b1);
    // offset far ahead keeps the parser skipping
    make_bmp(DEPTH_24, 2, 2, 0, 0, 2, 0);
    put_le(OFS_AT, 32'hFFFF_FFF0, 4);
    send_file(1'b1);
    // every byte a restart
    repeat (6) send_byte(8'($urandom), 1'b1);
    drain();

    // random traffic over the idling phases
    for (int p = 0; p < 4; p++) begin
      send_idle = send_plan[p];
      recv_stall = stall_plan[p];
      goal = bytes_sent + 80;
      while (bytes_sent < goal) random_file();
      drain();
    end

    board.leftover();
    $display("streamed %0d bytes in %0d files; checked %0d palette, %0d pixel, %0d error beats",
             bytes_sent, files_sent, board.palette_beats, board.pixel_beats,
             board.error_beats);
    $display("idling: none, sender, receiver and both, plus one long receiver hold-off");
    if (board.errors == 0) $display("bmp_stream_decoder_test: clean");
    else $display("bmp_stream_decoder_test: errors");
    $finish;
  end

endmodule
